FILE: src/log_record_checksum_defines.svh
// ----------------------------------------------------------------------------
// log_record_checksum_defines: assertion macros for the checksum block
// Shared property wrappers, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_CHECKSUM_DEFINES_SVH
`define LOG_RECORD_CHECKSUM_DEFINES_SVH

// Same-cycle implication.
`define LRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg: types and helpers for the log record checksum
// Item layouts, chunk sizes and the checksum fold.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam logic ACT_HEADER  = 1'b0;
  localparam logic ACT_CONTENT = 1'b1;

  localparam logic [3:0] CHUNK_NONE = 4'd0;
  localparam logic [3:0] CHUNK_B1   = 4'd1;
  localparam logic [3:0] CHUNK_B2   = 4'd2;
  localparam logic [3:0] CHUNK_B4   = 4'd4;
  localparam logic [3:0] CHUNK_B8   = 4'd8;

  typedef struct packed {
    logic               action;
    logic signed [63:0] record_id;
    logic signed [31:0] content_length;
    logic [15:0]        record_type;
    logic [7:0]         expected_sum;
    logic [7:0]         content_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] checksum_byte;
    logic       sum_matches;
  } result_t;

  // Largest chunk that still fits in the bytes left.
  function automatic logic [3:0] pick_chunk(input logic [30:0] left);
    logic [3:0] size;
    if (left >= 31'd8) begin
      size = CHUNK_B8;
    end else if (left >= 31'd4) begin
      size = CHUNK_B4;
    end else if (left >= 31'd2) begin
      size = CHUNK_B2;
    end else begin
      size = CHUNK_B1;
    end
    return size;
  endfunction

  // Fold by 32, 16 and 8 by adding the high half to the low half; only the low byte is kept,
  // so each step needs only the low half of the previous one.
  function automatic logic [7:0] fold_sum(input logic [63:0] s);
    logic [31:0] s32;
    logic [15:0] s16;
    logic [7:0]  s8;
    s32 = s[31:0] + s[63:32];
    s16 = s32[15:0] + s32[31:16];
    s8  = s16[7:0] + s16[15:8];
    return s8;
  endfunction

endpackage

FILE: src/log_record_checksum.sv
// ----------------------------------------------------------------------------
// log_record_checksum: one-byte checksum over a log record, computed and checked
//
//   channel  direction  payload
//   s_axis   in         tdata: record_id, content_length, record_type,
//                              expected_sum, content_byte; tuser: action
//   m_axis   out        tdata: checksum_byte, sum_matches
//
// One item per cycle sustained while the result is not stalled. An item is
// held in the input register, is folded into the record state by lrc_core
// and, when it closes a record, lands in the result register.
// Reset is asynchronous and leaves no record open and both registers empty.
// A stalled result holds the core; the input register still takes one item.
// ----------------------------------------------------------------------------
module log_record_checksum (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] record_id, [95:64] content_length, [111:96] record_type,
  // [119:112] expected_sum, [127:120] content_byte
  input  logic [127:0] s_axis_tdata,
  // [0] action
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] checksum_byte, [8] sum_matches, [15:9] zero
  output logic [15:0]  m_axis_tdata
);

  // Input register
  logic             in_valid_q, in_valid_d;
  lrc_pkg::item_t   in_item_q;
  logic             advance;

  // Result register
  logic             out_valid_q, out_valid_d;
  lrc_pkg::result_t out_res_q;

  logic             emit;
  lrc_pkg::result_t result;

  // Advance the held item whenever the result slot is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture the item payload on acceptance.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.action         <= s_axis_tuser[0];
      in_item_q.record_id      <= s_axis_tdata[63:0];
      in_item_q.content_length <= s_axis_tdata[95:64];
      in_item_q.record_type    <= s_axis_tdata[111:96];
      in_item_q.expected_sum   <= s_axis_tdata[119:112];
      in_item_q.content_byte   <= s_axis_tdata[127:120];
    end
  end

  lrc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (advance),
    .item_i   (in_item_q),
    .emit_o   (emit),
    .result_o (result)
  );

  // Load a result when the advancing item closes a record; drop it when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_res_q.sum_matches, out_res_q.checksum_byte};

endmodule

FILE: src/lrc_core.sv
// ----------------------------------------------------------------------------
// lrc_core: record state and per-item update
// Holds the running sums and chunk assembly; updates once per taken item.
// ----------------------------------------------------------------------------
module lrc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  lrc_pkg::item_t   item_i,
  output logic             emit_o,
  output lrc_pkg::result_t result_o
);

  logic [63:0] record_sum_q, record_sum_d;
  logic [63:0] chunk_acc_q, chunk_acc_d;
  logic [30:0] bytes_left_q, bytes_left_d;
  logic [63:0] chunk_word_q, chunk_word_d;
  logic [2:0]  chunk_fill_q, chunk_fill_d;
  logic [3:0]  chunk_size_q, chunk_size_d;
  logic [7:0]  expected_q, expected_d;
  logic        open_q, open_d;

  logic [63:0] hdr_sum;
  logic [63:0] word_new;
  logic [3:0]  fill_new;
  logic [63:0] word_ext;
  logic [63:0] acc_new;
  logic [63:0] sum_new;
  logic [30:0] left_new;
  logic [7:0]  folded;

  assign hdr_sum = item_i.record_id
                 + {{32{item_i.content_length[31]}}, item_i.content_length}
                 + {16'b0, item_i.record_type, 32'b0};

  assign word_new = chunk_word_q | ({56'b0, item_i.content_byte} << {chunk_fill_q, 3'b000});
  assign fill_new = {1'b0, chunk_fill_q} + 4'd1;

  always_comb begin
    case (chunk_size_q)
      lrc_pkg::CHUNK_B1: word_ext = {{56{word_new[7]}}, word_new[7:0]};
      lrc_pkg::CHUNK_B2: word_ext = {{48{word_new[15]}}, word_new[15:0]};
      lrc_pkg::CHUNK_B4: word_ext = {{32{word_new[31]}}, word_new[31:0]};
      default:           word_ext = word_new;
    endcase
  end

  assign acc_new  = chunk_acc_q + word_ext;
  assign sum_new  = record_sum_q + acc_new;
  assign left_new = bytes_left_q - {27'b0, chunk_size_q};

  always_comb begin
    record_sum_d = record_sum_q;
    chunk_acc_d  = chunk_acc_q;
    bytes_left_d = bytes_left_q;
    chunk_word_d = chunk_word_q;
    chunk_fill_d = chunk_fill_q;
    chunk_size_d = chunk_size_q;
    expected_d   = expected_q;
    open_d       = open_q;
    emit_o       = 1'b0;
    folded       = lrc_pkg::fold_sum(hdr_sum);
    if (item_i.action == lrc_pkg::ACT_HEADER) begin
      expected_d   = item_i.expected_sum;
      record_sum_d = hdr_sum;
      chunk_acc_d  = '0;
      chunk_word_d = '0;
      chunk_fill_d = '0;
      if (item_i.content_length == 32'sd0 || item_i.content_length[31]) begin
        bytes_left_d = '0;
        chunk_size_d = lrc_pkg::CHUNK_NONE;
        open_d       = 1'b0;
        emit_o       = 1'b1;
      end else begin
        bytes_left_d = item_i.content_length[30:0];
        chunk_size_d = lrc_pkg::pick_chunk(item_i.content_length[30:0]);
        open_d       = 1'b1;
      end
    end else if (open_q) begin
      if (fill_new < chunk_size_q) begin
        chunk_fill_d = fill_new[2:0];
        chunk_word_d = word_new;
      end else begin
        chunk_acc_d  = acc_new;
        record_sum_d = sum_new;
        bytes_left_d = left_new;
        chunk_word_d = '0;
        chunk_fill_d = '0;
        folded       = lrc_pkg::fold_sum(sum_new);
        if (left_new == 31'd0) begin
          chunk_size_d = lrc_pkg::CHUNK_NONE;
          open_d       = 1'b0;
          emit_o       = 1'b1;
        end else begin
          chunk_size_d = lrc_pkg::pick_chunk(left_new);
        end
      end
    end
  end

  assign result_o.checksum_byte = folded;
  assign result_o.sum_matches   = (folded == expected_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_sum_q <= '0;
      chunk_acc_q  <= '0;
      bytes_left_q <= '0;
      chunk_word_q <= '0;
      chunk_fill_q <= '0;
      chunk_size_q <= lrc_pkg::CHUNK_NONE;
      expected_q   <= '0;
      open_q       <= 1'b0;
    end else if (take_i) begin
      record_sum_q <= record_sum_d;
      chunk_acc_q  <= chunk_acc_d;
      bytes_left_q <= bytes_left_d;
      chunk_word_q <= chunk_word_d;
      chunk_fill_q <= chunk_fill_d;
      chunk_size_q <= chunk_size_d;
      expected_q   <= expected_d;
      open_q       <= open_d;
    end
  end

endmodule

FILE: src/lrc_checker.sv
// ----------------------------------------------------------------------------
// lrc_checker: port-level checks for the log record checksum
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
`include "log_record_checksum_defines.svh"

module lrc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [15:0]  m_axis_tdata
);

  `LRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  `LRC_ASSERT_NOW(a_ready_when_free, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled with result slot free")

  `LRC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[15:9] == 7'b0, "result padding not zero")

endmodule

bind log_record_checksum lrc_checker u_lrc_checker (.*);

FILE: test/lrc_record_check.sv
// ----------------------------------------------------------------------------
// lrc_record_check: scoreboard for the log record checksum
// Watches both stream channels, predicts each record's checksum result from
// the accepted items and compares every returned result with the oldest one
// still due.
// ----------------------------------------------------------------------------
module lrc_record_check (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [15:0]  m_axis_tdata,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);

  // Predicted record state.
  logic [63:0] rec_sum;
  logic [63:0] chunk_total;
  logic [30:0] bytes_due;
  logic [63:0] chunk_bits;
  logic [2:0]  chunk_got;
  logic [3:0]  chunk_len;
  logic [7:0]  stored_sum;
  logic        rec_open;

  lrc_pkg::result_t sums_due[$];
  int unsigned      mismatches;

  assign fail_count_o = mismatches;

  function automatic logic [3:0] chunk_for(input logic [30:0] remaining);
    if (remaining >= 31'd8) begin
      return lrc_pkg::CHUNK_B8;
    end else if (remaining >= 31'd4) begin
      return lrc_pkg::CHUNK_B4;
    end else if (remaining >= 31'd2) begin
      return lrc_pkg::CHUNK_B2;
    end
    return lrc_pkg::CHUNK_B1;
  endfunction

  // Fold the record sum down to one byte and queue the result.
  task automatic close_record();
    logic signed [63:0] s;
    lrc_pkg::result_t   r;
    s = rec_sum;
    s = s + (s >>> 32);
    s = s + (s >>> 16);
    s = s + (s >>> 8);
    r.checksum_byte = s[7:0];
    r.sum_matches   = (s[7:0] == stored_sum);
    sums_due.push_back(r);
  endtask

  task automatic absorb_item(input logic act, input logic [127:0] d);
    logic [63:0] rid;
    logic [31:0] clen;
    logic [15:0] rtype;
    logic [7:0]  cbyte;
    logic [3:0]  filled;
    logic [63:0] chunk_val;
    rid   = d[63:0];
    clen  = d[95:64];
    rtype = d[111:96];
    cbyte = d[127:120];
    if (act == lrc_pkg::ACT_HEADER) begin
      stored_sum  = d[119:112];
      rec_sum     = rid + {{32{clen[31]}}, clen} + {16'd0, rtype, 32'd0};
      chunk_total = '0;
      chunk_bits  = '0;
      chunk_got   = '0;
      if (clen == 32'd0 || clen[31]) begin
        // empty or removal record: result straight from the header
        bytes_due = '0;
        chunk_len = lrc_pkg::CHUNK_NONE;
        rec_open  = 1'b0;
        close_record();
      end else begin
        bytes_due = clen[30:0];
        chunk_len = chunk_for(clen[30:0]);
        rec_open  = 1'b1;
      end
    end else if (rec_open) begin
      chunk_bits = chunk_bits | ({56'd0, cbyte} << {chunk_got, 3'b000});
      filled     = {1'b0, chunk_got} + 4'd1;
      if (filled < chunk_len) begin
        chunk_got = filled[2:0];
      end else begin
        case (chunk_len)
          lrc_pkg::CHUNK_B1: chunk_val = {{56{chunk_bits[7]}}, chunk_bits[7:0]};
          lrc_pkg::CHUNK_B2: chunk_val = {{48{chunk_bits[15]}}, chunk_bits[15:0]};
          lrc_pkg::CHUNK_B4: chunk_val = {{32{chunk_bits[31]}}, chunk_bits[31:0]};
          default:           chunk_val = chunk_bits;
        endcase
        chunk_total = chunk_total + chunk_val;
        rec_sum     = rec_sum + chunk_total;
        bytes_due   = bytes_due - {27'd0, chunk_len};
        chunk_bits  = '0;
        chunk_got   = '0;
        if (bytes_due == 31'd0) begin
          chunk_len = lrc_pkg::CHUNK_NONE;
          rec_open  = 1'b0;
          close_record();
        end else begin
          chunk_len = chunk_for(bytes_due);
        end
      end
    end
  endtask

  task automatic check_result(input logic [15:0] d);
    lrc_pkg::result_t want;
    if (sums_due.size() == 0) begin
      $display("ERROR %0t: result %04h with none expected", $time, d);
      mismatches++;
    end else begin
      want = sums_due.pop_front();
      if (d[7:0] !== want.checksum_byte) begin
        $display("ERROR %0t: checksum_byte expected %02h actual %02h",
                 $time, want.checksum_byte, d[7:0]);
        mismatches++;
      end
      if (d[8] !== want.sum_matches) begin
        $display("ERROR %0t: sum_matches expected %0b actual %0b",
                 $time, want.sum_matches, d[8]);
        mismatches++;
      end
      if (d[15:9] !== 7'd0) begin
        $display("ERROR %0t: pad bits expected 00 actual %02h", $time, d[15:9]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_sum     = '0;
      chunk_total = '0;
      bytes_due   = '0;
      chunk_bits  = '0;
      chunk_got   = '0;
      chunk_len   = lrc_pkg::CHUNK_NONE;
      stored_sum  = '0;
      rec_open    = 1'b0;
      mismatches  = 0;
      sums_due.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_item(s_axis_tuser[0], s_axis_tdata);
      end
      pending_o <= sums_due.size();
    end
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for log_record_checksum
// Drives directed and random log records with random idling on both sides,
// a long receiver hold-off and replayed records whose stored checksum is the
// one just returned; lrc_record_check predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_ITEMS   = 850;
  localparam int HOLD_AT_ITEMS  = 300;
  localparam int TAIL_AT_ITEMS  = 750;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;

  int unsigned  fail_count;
  int unsigned  results_due;
  int unsigned  items_sent = 0;
  int unsigned  gap_odds = 0;
  int unsigned  idle_cycles = 0;
  bit           quiet_tail = 1'b0;
  bit           long_hold_req = 1'b0;
  logic [7:0]   last_checksum = '0;

  log_record_checksum DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lrc_record_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (results_due)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Keep the last returned checksum so a record can be replayed to match.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      last_checksum <= m_axis_tdata[7:0];
    end
  end

  // Abort when no item moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none in the tail.
  initial begin
    int unsigned stall_odds;
    stall_odds = 8;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, stall_odds) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        stall_odds = $urandom_range(2, 30);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [127:0] header_word(input logic [63:0] rid,
                                               input logic [31:0] clen,
                                               input logic [15:0] rtype,
                                               input logic [7:0]  xsum);
    // content_byte is unused on a header: fill it with noise
    return {8'($urandom), xsum, rtype, clen, rid};
  endfunction

  function automatic logic [127:0] content_word(input logic [7:0] b);
    // header fields are unused on content: fill them with noise
    return {b, $urandom, $urandom, $urandom, 24'($urandom)};
  endfunction

  // Offer one item, with an optional idle burst first; return once accepted.
  task automatic put_item(input logic act, input logic [127:0] d);
    if (!quiet_tail && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_record(input logic [63:0] rid, input logic [31:0] clen,
                             input logic [15:0] rtype, input logic [7:0] xsum,
                             input logic [7:0] body[$]);
    put_item(lrc_pkg::ACT_HEADER, header_word(rid, clen, rtype, xsum));
    foreach (body[i]) begin
      put_item(lrc_pkg::ACT_CONTENT, content_word(body[i]));
    end
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  body[$];
    logic [63:0] rid;
    logic [31:0] clen;
    logic [15:0] rtype;
    logic [7:0]  xsum;
    int unsigned kind;
    int unsigned nbytes;
    bit          edgy;
    bit          hold_done;

    hold_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gap_odds = 4;

    // Empty record at the identifier and type maxima.
    body.delete();
    send_record(64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 16'hFFFF, 8'h00, body);
    // Removal records: length -1 and the most negative length.
    send_record(64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 16'h0000, 8'hFF, body);
    send_record(64'h0, 32'h8000_0000, 16'h8001, 8'h5A, body);
    // Stray content byte with no record open: ignored.
    put_item(lrc_pkg::ACT_CONTENT, content_word(8'hA5));
    // Fifteen bytes walk through chunks of 8, 4, 2 and 1 with signed edges.
    body = '{8'hFF, 8'h80, 8'h00, 8'h7F, 8'h01, 8'hFE, 8'h80, 8'hFF,
             8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h80};
    send_record(64'hFFFF_FFFF_FFFF_FFFF, 32'd15, 16'hFFFF, 8'h3C, body);
    // Largest length, abandoned by the next header after one byte.
    body = '{8'h42};
    send_record(64'h0123_4567_89AB_CDEF, 32'h7FFF_FFFF, 16'h1234, 8'h00, body);
    body.delete();
    send_record(64'hFEDC_BA98_7654_3210, 32'd0, 16'hABCD, 8'h11, body);
    // Replay the last header with its own checksum stored: must match.
    wait_for_results();
    send_record(64'hFEDC_BA98_7654_3210, 32'd0, 16'hABCD, last_checksum, body);

    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_done && items_sent >= HOLD_AT_ITEMS) begin
        // Stall the receiver while empty records keep coming: fill the block.
        hold_done = 1'b1;
        long_hold_req = 1'b1;
        gap_odds = 0;
        body.delete();
        repeat (40) begin
          send_record({$urandom, $urandom}, 32'd0, 16'($urandom), 8'($urandom), body);
        end
        continue;
      end
      if (items_sent >= TAIL_AT_ITEMS) begin
        quiet_tail = 1'b1;
      end
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
      rid   = {$urandom, $urandom};
      rtype = 16'($urandom);
      xsum  = 8'($urandom);
      edgy  = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 99);
      body.delete();
      if (kind < 8) begin
        // removal record
        send_record(rid, {1'b1, 31'($urandom)}, rtype, xsum, body);
      end else if (kind < 14) begin
        send_record(rid, 32'd0, rtype, xsum, body);
      end else if (kind < 20) begin
        // huge length, cut short by whatever comes next
        nbytes = $urandom_range(0, 9);
        repeat (nbytes) body.push_back(8'($urandom));
        send_record(rid, {1'b0, 31'($urandom)}, rtype, xsum, body);
      end else if (kind < 26) begin
        // truncated record
        clen   = $urandom_range(2, 30);
        nbytes = $urandom_range(0, clen - 1);
        repeat (nbytes) body.push_back(8'($urandom));
        send_record(rid, clen, rtype, xsum, body);
      end else if (kind < 30) begin
        // loose content bytes
        repeat ($urandom_range(1, 4)) begin
          put_item(lrc_pkg::ACT_CONTENT, content_word(8'($urandom)));
        end
      end else begin
        clen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                           : $urandom_range(1, 24);
        repeat (clen) begin
          if (edgy) begin
            case ($urandom_range(0, 3))
              0:       body.push_back(8'h00);
              1:       body.push_back(8'hFF);
              2:       body.push_back(8'h80);
              default: body.push_back(8'h7F);
            endcase
          end else begin
            body.push_back(8'($urandom));
          end
        end
        send_record(rid, clen, rtype, xsum, body);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
          // pause until drained, then replay with the returned checksum
          wait_for_results();
          send_record(rid, clen, rtype, last_checksum, body);
        end
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: log_record_checksum.f
+incdir+src
src/lrc_pkg.sv
src/lrc_core.sv
src/log_record_checksum.sv
src/lrc_checker.sv
test/lrc_record_check.sv
test/tb.sv
